[rtl/mnjt_pkg.sv]
package mnjt_pkg;

	localparam int MAX_NODES = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;

	localparam logic [1:0] MODE_FREE = 2'd0;
	localparam logic [1:0] MODE_JOINING = 2'd1;
	localparam logic [1:0] MODE_CONNECTED = 2'd2;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_RESERVE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] REG_PROTOCOL_ID = 2'd0;
	localparam logic [1:0] REG_NODE_COUNT = 2'd1;
	localparam logic [1:0] REG_SEND_PERIOD = 2'd2;
	localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd3;

	localparam logic [3:0] EV_IGNORED = 4'd0;
	localparam logic [3:0] EV_JOINED = 4'd1;
	localparam logic [3:0] EV_JOIN_REFRESHED = 4'd2;
	localparam logic [3:0] EV_FULL = 4'd3;
	localparam logic [3:0] EV_CONNECTED = 4'd4;
	localparam logic [3:0] EV_KEEPALIVE = 4'd5;
	localparam logic [3:0] EV_SEND_ACCEPT = 4'd6;
	localparam logic [3:0] EV_SEND_UPDATE = 4'd7;
	localparam logic [3:0] EV_TIMED_OUT = 4'd8;
	localparam logic [3:0] EV_RESERVED = 4'd9;
	localparam logic [3:0] EV_CLEARED = 4'd10;
	localparam logic [3:0] EV_TICK_DONE = 4'd11;

	localparam logic [7:0] TYPE_JOIN = 8'd0;
	localparam logic [7:0] TYPE_KEEPALIVE = 8'd1;

	localparam logic [4:0] NODE_COUNT_RST = 5'd16;
	localparam logic [15:0] SEND_PERIOD_RST = 16'd100;
	localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd1000;

	typedef struct packed {
		logic capture;
		logic idx_clr;
		logic idx_inc;
		logic scan;
		logic tick_acc;
		logic send_step;
		logic age_step;
		logic finish;
	} mnjt_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic hdr_ok;
		logic idx_last;
		logic send_due;
		logic send_need;
		logic age_need;
		logic out_free;
	} mnjt_status_t;

endpackage

[rtl/mnjt_ctrl.sv]
module mnjt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  mnjt_pkg::mnjt_status_t st,
	output mnjt_pkg::mnjt_cmd_t    cmd
);
	import mnjt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_TICK = 3'd2;
	localparam logic [2:0] S_SEND = 3'd3;
	localparam logic [2:0] S_AGE = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.idx_clr = 1'b1;
					unique case (st.op)
						OP_PACKET: state_d = S_SCAN;
						OP_TICK: state_d = S_TICK;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.idx_inc = 1'b1;
				if (st.idx_last || !st.hdr_ok) begin
					state_d = S_FINISH;
				end
			end
			S_TICK: begin
				cmd.tick_acc = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d = st.send_due ? S_SEND : S_AGE;
			end
			S_SEND: begin
				if (!st.send_need || st.out_free) begin
					cmd.send_step = 1'b1;
					if (st.idx_last) begin
						cmd.idx_clr = 1'b1;
						state_d = S_AGE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_AGE: begin
				if (!st.age_need || st.out_free) begin
					cmd.age_step = 1'b1;
					cmd.idx_inc = 1'b1;
					if (st.idx_last) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/mnjt_dp.sv]
module mnjt_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic [1:0]             op,
	input  logic [31:0]            sender_addr,
	input  logic [15:0]            sender_port,
	input  logic [31:0]            header_protocol,
	input  logic [7:0]             packet_type,
	input  logic [15:0]            delta_time,
	input  logic [3:0]             slot_index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [3:0]             event_res,
	output logic [3:0]             slot,
	output logic [31:0]            peer_addr,
	output logic [15:0]            peer_port,
	output logic                   last,
	input  mnjt_pkg::mnjt_cmd_t    cmd,
	output mnjt_pkg::mnjt_status_t st
);
	import mnjt_pkg::*;

	logic [31:0] protocol_id_q;
	logic [4:0]  node_count_q;
	logic [15:0] send_period_q;
	logic [15:0] timeout_limit_q;

	logic [1:0]  mode_q [MAX_NODES];
	logic [47:0] peer_tab_q [MAX_NODES];
	logic [15:0] sil_q [MAX_NODES];
	logic [16:0] accum_q;

	logic [1:0]       op_q;
	logic [47:0]      peer_q;
	logic             hdr_ok_q;
	logic             is_keep_q;
	logic [15:0]      d_q;
	logic [IDX_W-1:0] rsv_idx_q;
	logic [IDX_W-1:0] idx_q;

	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [1:0]       match_mode_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [CNT_W-1:0] n_act;
	logic             occ;
	logic [16:0]      accum_sum;
	logic             due;
	logic [16:0]      sil_sum;
	logic [15:0]      sil_new;
	logic             expire;

	logic             out_free;
	logic             emit;
	logic [3:0]       e_ev;
	logic [IDX_W-1:0] e_slot;
	logic [47:0]      e_peer;

	always_comb begin
		if (node_count_q == '0) begin
			n_act = CNT_W'(1);
		end else if (node_count_q > CNT_W'(MAX_NODES)) begin
			n_act = CNT_W'(MAX_NODES);
		end else begin
			n_act = node_count_q;
		end
	end

	assign occ = (mode_q[idx_q] != MODE_FREE);
	assign accum_sum = accum_q + {1'b0, d_q};
	assign due = accum_sum > {1'b0, send_period_q};
	assign sil_sum = {1'b0, sil_q[idx_q]} + {1'b0, d_q};
	assign sil_new = sil_sum[16] ? 16'hFFFF : sil_sum[15:0];
	assign expire = occ && (sil_new > timeout_limit_q);
	assign out_free = !out_valid || !out_stall;

	assign st.op = op;
	assign st.hdr_ok = hdr_ok_q;
	assign st.idx_last = ({1'b0, idx_q} == (n_act - CNT_W'(1)));
	assign st.send_due = due;
	assign st.send_need = occ;
	assign st.age_need = expire;
	assign st.out_free = out_free;

	always_comb begin
		emit = 1'b0;
		e_ev = EV_IGNORED;
		e_slot = '0;
		e_peer = '0;
		if (cmd.send_step && occ) begin
			emit = 1'b1;
			e_ev = (mode_q[idx_q] == MODE_JOINING) ? EV_SEND_ACCEPT : EV_SEND_UPDATE;
			e_slot = idx_q;
			e_peer = peer_tab_q[idx_q];
		end else if (cmd.age_step && expire) begin
			emit = 1'b1;
			e_ev = EV_TIMED_OUT;
			e_slot = idx_q;
			e_peer = peer_tab_q[idx_q];
		end else if (cmd.finish) begin
			emit = 1'b1;
			unique case (op_q)
				OP_PACKET: begin
					if (!hdr_ok_q) begin
						e_ev = EV_IGNORED;
					end else if (!is_keep_q) begin
						if (!match_q) begin
							e_peer = peer_q;
							if (free_q) begin
								e_ev = EV_JOINED;
								e_slot = free_idx_q;
							end else begin
								e_ev = EV_FULL;
							end
						end else if (match_mode_q == MODE_JOINING) begin
							e_ev = EV_JOIN_REFRESHED;
							e_slot = match_idx_q;
							e_peer = peer_q;
						end
					end else if (match_q) begin
						e_ev = (match_mode_q == MODE_JOINING) ? EV_CONNECTED : EV_KEEPALIVE;
						e_slot = match_idx_q;
						e_peer = peer_q;
					end
				end
				OP_TICK: e_ev = EV_TICK_DONE;
				OP_RESERVE: begin
					if ({1'b0, rsv_idx_q} < n_act) begin
						e_ev = EV_RESERVED;
						e_slot = rsv_idx_q;
						e_peer = peer_q;
					end
				end
				default: e_ev = EV_CLEARED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_id_q <= '0;
			node_count_q <= NODE_COUNT_RST;
			send_period_q <= SEND_PERIOD_RST;
			timeout_limit_q <= TIMEOUT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROTOCOL_ID: protocol_id_q <= cfg_data;
				REG_NODE_COUNT: node_count_q <= cfg_data[4:0];
				REG_SEND_PERIOD: send_period_q <= cfg_data[15:0];
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op;
			peer_q <= {sender_addr, sender_port};
			hdr_ok_q <= (header_protocol == protocol_id_q) &&
				(packet_type == TYPE_JOIN || packet_type == TYPE_KEEPALIVE);
			is_keep_q <= (packet_type == TYPE_KEEPALIVE);
			d_q <= (delta_time > send_period_q) ? send_period_q : delta_time;
			rsv_idx_q <= slot_index;
		end
		if (cmd.scan) begin
			if (occ && peer_tab_q[idx_q] == peer_q && !match_q) begin
				match_idx_q <= idx_q;
				match_mode_q <= mode_q[idx_q];
			end
			if (!occ && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			match_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.capture) begin
				match_q <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.scan) begin
				if (occ && peer_tab_q[idx_q] == peer_q) begin
					match_q <= 1'b1;
				end
				if (!occ) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				mode_q[i] <= MODE_FREE;
				peer_tab_q[i] <= '0;
				sil_q[i] <= '0;
			end
			accum_q <= '0;
		end else begin
			if (cmd.tick_acc) begin
				accum_q <= due ? (accum_sum - {1'b0, send_period_q}) : accum_sum;
			end
			if (cmd.age_step && occ) begin
				if (expire) begin
					mode_q[idx_q] <= MODE_FREE;
					peer_tab_q[idx_q] <= '0;
					sil_q[idx_q] <= '0;
				end else begin
					sil_q[idx_q] <= sil_new;
				end
			end
			if (cmd.finish) begin
				unique case (op_q)
					OP_PACKET: begin
						if (hdr_ok_q) begin
							if (!is_keep_q) begin
								if (!match_q && free_q) begin
									mode_q[free_idx_q] <= MODE_JOINING;
									peer_tab_q[free_idx_q] <= peer_q;
									sil_q[free_idx_q] <= '0;
								end else if (match_q && match_mode_q == MODE_JOINING) begin
									sil_q[match_idx_q] <= '0;
								end
							end else if (match_q) begin
								sil_q[match_idx_q] <= '0;
								if (match_mode_q == MODE_JOINING) begin
									mode_q[match_idx_q] <= MODE_CONNECTED;
								end
							end
						end
					end
					OP_TICK: ;
					OP_RESERVE: begin
						if ({1'b0, rsv_idx_q} < n_act) begin
							mode_q[rsv_idx_q] <= MODE_JOINING;
							peer_tab_q[rsv_idx_q] <= peer_q;
							sil_q[rsv_idx_q] <= '0;
						end
					end
					default: begin
						for (int i = 0; i < MAX_NODES; i++) begin
							mode_q[i] <= MODE_FREE;
							peer_tab_q[i] <= '0;
							sil_q[i] <= '0;
						end
						accum_q <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			event_res <= e_ev;
			slot <= e_slot;
			peer_addr <= e_peer[47:16];
			peer_port <= e_peer[15:0];
			last <= cmd.finish;
		end
	end

endmodule

[rtl/mesh_node_join_table.sv]
// A packet is captured, scanned against the active slots (the scan stops early on a bad
// header) and then committed; reserve and clear are captured and committed; a tick adds its
// time, runs a send round over the active slots when one is due, then ages the active slots.
// The block takes one transaction at a time, set by the single slot walk of the datapath.
// A stalled output holds the walk only when a result is waiting.
// Reset (arst_n low): all slots free and zeroed, send accumulator zero, registers at defaults.
module mesh_node_join_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] sender_addr,
	input  logic [15:0] sender_port,
	input  logic [31:0] header_protocol,
	input  logic [7:0]  packet_type,
	input  logic [15:0] delta_time,
	input  logic [3:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_res,
	output logic [3:0]  slot,
	output logic [31:0] peer_addr,
	output logic [15:0] peer_port,
	output logic        last
);
	import mnjt_pkg::*;

	mnjt_cmd_t    cmd;
	mnjt_status_t st;

	mnjt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	mnjt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.op              (op),
		.sender_addr     (sender_addr),
		.sender_port     (sender_port),
		.header_protocol (header_protocol),
		.packet_type     (packet_type),
		.delta_time      (delta_time),
		.slot_index      (slot_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_res       (event_res),
		.slot            (slot),
		.peer_addr       (peer_addr),
		.peer_port       (peer_port),
		.last            (last),
		.cmd             (cmd),
		.st              (st)
	);

endmodule

[tb/mesh_node_join_table_tb.sv]
`timescale 1ns / 100ps

import mnjt_pkg::*;

typedef struct packed {
	logic [3:0]  ev;
	logic [3:0]  slot;
	logic [31:0] addr;
	logic [15:0] port;
	logic        last;
} join_event_t;

class join_table_scoreboard;
	logic [31:0] protocol_id;
	logic [4:0]  node_count;
	logic [15:0] send_period;
	logic [15:0] timeout_limit;
	logic [1:0]  mode [MAX_NODES];
	logic [47:0] peer [MAX_NODES];
	logic [16:0] silence [MAX_NODES];
	logic [16:0] accum;
	join_event_t pending [$];
	int errors;

	function void reset_table();
		protocol_id = 0;
		node_count = NODE_COUNT_RST;
		send_period = SEND_PERIOD_RST;
		timeout_limit = TIMEOUT_LIMIT_RST;
		accum = 0;
		errors = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			mode[i] = MODE_FREE;
			peer[i] = 0;
			silence[i] = 0;
		end
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			REG_PROTOCOL_ID: protocol_id = val;
			REG_NODE_COUNT: node_count = val[4:0];
			REG_SEND_PERIOD: send_period = val[15:0];
			default: timeout_limit = val[15:0];
		endcase
	endfunction

	function int active_slots();
		if (node_count < 1) return 1;
		if (node_count > MAX_NODES) return MAX_NODES;
		return node_count;
	endfunction

	function void push(logic [3:0] ev, int s, logic [47:0] p);
		join_event_t e;
		e.ev = ev;
		e.slot = s[3:0];
		e.addr = p[47:16];
		e.port = p[15:0];
		e.last = 0;
		pending.push_back(e);
	endfunction

	function void note_input(logic [1:0] op, logic [31:0] addr, logic [15:0] port,
			logic [31:0] hdr, logic [7:0] ptype, logic [15:0] delta, logic [3:0] sidx);
		logic [47:0] p;
		int n, s, found;
		logic [16:0] d, t;
		p = {addr, port};
		n = active_slots();
		found = -1;
		for (int i = 0; i < n; i++)
			if (found < 0 && mode[i] != MODE_FREE && peer[i] == p) found = i;
		case (op)
			OP_PACKET: begin
				if (hdr != protocol_id || ptype > TYPE_KEEPALIVE) begin
					push(EV_IGNORED, 0, 0);
				end else if (ptype == TYPE_JOIN) begin
					if (found < 0) begin
						s = -1;
						for (int i = 0; i < n; i++)
							if (s < 0 && mode[i] == MODE_FREE) s = i;
						if (s < 0) begin
							push(EV_FULL, 0, p);
						end else begin
							mode[s] = MODE_JOINING;
							peer[s] = p;
							silence[s] = 0;
							push(EV_JOINED, s, p);
						end
					end else if (mode[found] == MODE_JOINING) begin
						silence[found] = 0;
						push(EV_JOIN_REFRESHED, found, p);
					end else begin
						push(EV_IGNORED, 0, 0);
					end
				end else if (found < 0) begin
					push(EV_IGNORED, 0, 0);
				end else begin
					silence[found] = 0;
					if (mode[found] == MODE_JOINING) begin
						mode[found] = MODE_CONNECTED;
						push(EV_CONNECTED, found, p);
					end else begin
						push(EV_KEEPALIVE, found, p);
					end
				end
			end
			OP_TICK: begin
				d = (delta > send_period) ? send_period : delta;
				accum = accum + d;
				if (accum > send_period) begin
					for (int i = 0; i < n; i++)
						if (mode[i] == MODE_JOINING) push(EV_SEND_ACCEPT, i, peer[i]);
						else if (mode[i] == MODE_CONNECTED) push(EV_SEND_UPDATE, i, peer[i]);
					accum = accum - send_period;
				end
				for (int i = 0; i < n; i++) begin
					if (mode[i] != MODE_FREE) begin
						t = silence[i] + d;
						if (t > 17'hFFFF) t = 17'hFFFF;
						silence[i] = t;
						if (t > timeout_limit) begin
							push(EV_TIMED_OUT, i, peer[i]);
							mode[i] = MODE_FREE;
							peer[i] = 0;
							silence[i] = 0;
						end
					end
				end
				push(EV_TICK_DONE, 0, 0);
			end
			OP_RESERVE: begin
				if (sidx >= n) begin
					push(EV_IGNORED, 0, 0);
				end else begin
					mode[sidx] = MODE_JOINING;
					peer[sidx] = p;
					silence[sidx] = 0;
					push(EV_RESERVED, sidx, p);
				end
			end
			default: begin
				for (int i = 0; i < MAX_NODES; i++) begin
					mode[i] = MODE_FREE;
					peer[i] = 0;
					silence[i] = 0;
				end
				accum = 0;
				push(EV_CLEARED, 0, 0);
			end
		endcase
		pending[$].last = 1;
	endfunction

	function void check_result(join_event_t got);
		join_event_t e;
		if (pending.size() == 0) begin
			$error("unexpected result event_res=%0d", got.ev);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.ev !== e.ev) begin
			$error("event_res expected %0d actual %0d", e.ev, got.ev);
			errors++;
		end
		if (got.slot !== e.slot) begin
			$error("slot expected %0d actual %0d", e.slot, got.slot);
			errors++;
		end
		if (got.addr !== e.addr) begin
			$error("peer_addr expected %h actual %h", e.addr, got.addr);
			errors++;
		end
		if (got.port !== e.port) begin
			$error("peer_port expected %h actual %h", e.port, got.port);
			errors++;
		end
		if (got.last !== e.last) begin
			$error("last expected %0d actual %0d", e.last, got.last);
			errors++;
		end
	endfunction
endclass

module mesh_node_join_table_tb;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] op = 0;
	logic [31:0] sender_addr = 0;
	logic [15:0] sender_port = 0;
	logic [31:0] header_protocol = 0;
	logic [7:0] packet_type = 0;
	logic [15:0] delta_time = 0;
	logic [3:0] slot_index = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [3:0] event_res;
	logic [3:0] slot;
	logic [31:0] peer_addr;
	logic [15:0] peer_port;
	logic last;

	join_table_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int cycles;
	logic [31:0] peer_addrs [4];
	logic [15:0] peer_ports [4];

	mesh_node_join_table dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("mesh_node_join_table_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{event_res, slot, peer_addr, peer_port, last});
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_item(logic [1:0] o, logic [31:0] a, logic [15:0] p, logic [31:0] h,
			logic [7:0] t, logic [15:0] d, logic [3:0] s);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1;
		op <= o;
		sender_addr <= a;
		sender_port <= p;
		header_protocol <= h;
		packet_type <= t;
		delta_time <= d;
		slot_index <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(o, a, p, h, t, d, s);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_items(int count);
		int k, r;
		logic [7:0] t;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(3);
			r = $urandom_range(99);
			t = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1));
			if (r < 55)
				send_item(OP_PACKET, peer_addrs[k], peer_ports[k],
					($urandom_range(9) == 0) ? $urandom : board.protocol_id, t, 0, 0);
			else if (r < 65)
				send_item(OP_PACKET, $urandom, 16'($urandom), board.protocol_id, t, 0, 0);
			else if (r < 88)
				send_item(OP_TICK, $urandom, 16'($urandom), $urandom, 8'($urandom),
					($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(300)), 0);
			else if (r < 97)
				send_item(OP_RESERVE, peer_addrs[k], peer_ports[k], 0, 0, 0,
					4'($urandom));
			else
				send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		end
	endtask

	initial begin
		board = new();
		board.reset_table();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 4; i++) begin
			peer_addrs[i] = $urandom;
			peer_ports[i] = 16'($urandom);
		end
		peer_addrs[0] = 32'hFFFF_FFFF;
		peer_ports[0] = 16'hFFFF;
		peer_addrs[1] = 0;
		peer_ports[1] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: joins, refresh, connect, keepalive, rejects, full table, reserve, clear.
		write_reg(REG_PROTOCOL_ID, 32'hFFFF_FFFF);
		write_reg(REG_NODE_COUNT, 2);
		write_reg(REG_SEND_PERIOD, 10);
		write_reg(REG_TIMEOUT_LIMIT, 25);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'h0, TYPE_JOIN, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, 8'hFF, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, TYPE_KEEPALIVE, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, TYPE_JOIN, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, TYPE_JOIN, 0, 0);
		send_item(OP_PACKET, peer_addrs[1], peer_ports[1], 32'hFFFF_FFFF, TYPE_JOIN, 0, 0);
		send_item(OP_PACKET, peer_addrs[2], peer_ports[2], 32'hFFFF_FFFF, TYPE_JOIN, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, TYPE_KEEPALIVE, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, TYPE_KEEPALIVE, 0, 0);
		send_item(OP_PACKET, peer_addrs[0], peer_ports[0], 32'hFFFF_FFFF, TYPE_JOIN, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
		send_item(OP_TICK, 0, 0, 0, 0, 0, 0);
		send_item(OP_TICK, 0, 0, 0, 0, 7, 0);
		send_item(OP_TICK, 0, 0, 0, 0, 10, 0);
		send_item(OP_RESERVE, peer_addrs[3], peer_ports[3], 0, 0, 0, 4'd1);
		send_item(OP_RESERVE, peer_addrs[3], peer_ports[3], 0, 0, 0, 4'd15);
		send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		drain();
		write_reg(REG_NODE_COUNT, 0);
		write_reg(REG_TIMEOUT_LIMIT, 0);
		send_item(OP_RESERVE, peer_addrs[2], peer_ports[2], 0, 0, 0, 4'd0);
		send_item(OP_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
		drain();
		write_reg(REG_NODE_COUNT, 31);
		write_reg(REG_SEND_PERIOD, 16'hFFFF);
		write_reg(REG_TIMEOUT_LIMIT, 16'hFFFF);
		send_item(OP_RESERVE, peer_addrs[2], peer_ports[2], 0, 0, 0, 4'd15);
		send_item(OP_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
		send_item(OP_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
		drain();

		write_reg(REG_PROTOCOL_ID, $urandom);
		write_reg(REG_NODE_COUNT, 3);
		write_reg(REG_SEND_PERIOD, 40);
		write_reg(REG_TIMEOUT_LIMIT, 200);
		send_idle_pct = 30;
		recv_idle_pct = 78;
		random_items(26);
		drain();
		write_reg(REG_PROTOCOL_ID, 0);
		write_reg(REG_NODE_COUNT, 16);
		write_reg(REG_SEND_PERIOD, 1);
		write_reg(REG_TIMEOUT_LIMIT, 500);
		send_idle_pct = 78;
		recv_idle_pct = 30;
		random_items(26);
		drain();
		write_reg(REG_NODE_COUNT, 5);
		write_reg(REG_SEND_PERIOD, 100);
		write_reg(REG_TIMEOUT_LIMIT, 1000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(26);
		drain();

		if (board.errors == 0) begin
			$display("mesh_node_join_table_tb: clean");
		end else begin
			$display("mesh_node_join_table_tb: errors");
		end
		$finish;
	end
endmodule

[files.f]
rtl/mnjt_pkg.sv
rtl/mnjt_ctrl.sv
rtl/mnjt_dp.sv
rtl/mesh_node_join_table.sv
tb/mesh_node_join_table_tb.sv
